### design/rabt_pkg.sv
package rabt_pkg;

    // Threshold register
    localparam int unsigned THRESH_BITS = 10;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd512;

    // Width of the count fields in a result item
    localparam int unsigned OUT_BITS = 16;

    // Scale of the left side: 1.96^2 taken as 38416 / 10000
    localparam int unsigned K_LHS      = 10000;
    localparam int unsigned K_LHS_BITS = 14;

    // Scale of the right side: 38416 * 8
    localparam int unsigned K_RHS      = 307328;
    localparam int unsigned K_RHS_BITS = 19;

endpackage

### design/rabt_ifs.sv
interface rabt_in_if #(
    parameter int unsigned SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rabt_out_if;
    logic                          valid;
    logic                          ready;
    logic [rabt_pkg::OUT_BITS-1:0] run_count;
    logic [rabt_pkg::OUT_BITS-1:0] above_count;
    logic [rabt_pkg::OUT_BITS-1:0] below_count;
    logic                          accepted;
    logic                          degenerate;

    modport source (
        output valid, output run_count, output above_count, output below_count,
        output accepted, output degenerate, input ready
    );
    modport sink (
        input valid, input run_count, input above_count, input below_count,
        input accepted, input degenerate, output ready
    );
endinterface

### design/rabt_mul.sv
module rabt_mul #(
    parameter int unsigned ACC_BITS  = 101,
    parameter int unsigned MPY_BITS  = 35,
    parameter int unsigned STEP_BITS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [ACC_BITS-1:0]  mcand,
    input  logic [MPY_BITS-1:0]  mplier,
    input  logic [STEP_BITS-1:0] nbits,
    output logic [ACC_BITS-1:0]  product,
    output logic                 done
);

    logic [ACC_BITS-1:0]  acc_reg,    acc_next;
    logic [ACC_BITS-1:0]  mcand_reg,  mcand_next;
    logic [MPY_BITS-1:0]  mplier_reg, mplier_next;
    logic [STEP_BITS-1:0] cnt_reg,    cnt_next;

    // Shift-add step: one multiplier bit per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        if (load)
        begin
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            cnt_next    = nbits;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[ACC_BITS-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MPY_BITS-1:1]};
            cnt_next    = cnt_reg - STEP_BITS'(1);
        end
    end

    // Hold the step count under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product = acc_reg;
    assign done    = (cnt_reg == '0);

endmodule

### design/runs_above_below_test.sv
// Non-last item: taken while idle; the block stays ready for the next item.
// Last item: the result follows seven products on one shift-add multiplier,
// one multiplier bit per cycle; no item is taken meanwhile. A waiting result
// holds the block until the output register frees.
// Reset: threshold 512, all counts cleared, no result pending.
module runs_above_below_test #(
    parameter int unsigned SAMPLE_BITS = 10,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rabt_pkg::THRESH_BITS-1:0]  cfg_wr_data,
    rabt_in_if.sink                           samples,
    rabt_out_if.source                        verdicts
);

    localparam int unsigned NW   = COUNT_BITS + 1;
    localparam int unsigned PW   = 2 * COUNT_BITS;
    localparam int unsigned DW   = 2 * COUNT_BITS + 3;
    localparam int unsigned SW   = 2 * COUNT_BITS + 1;
    localparam int unsigned LW   = 5 * COUNT_BITS + 21;
    localparam int unsigned MW   = (DW > rabt_pkg::K_RHS_BITS) ? DW : rabt_pkg::K_RHS_BITS;
    localparam int unsigned CNTW = $clog2(MW + 1);
    localparam int unsigned CMPW = (SAMPLE_BITS > rabt_pkg::THRESH_BITS) ?
                                   SAMPLE_BITS : rabt_pkg::THRESH_BITS;
    localparam int unsigned OXW  = (COUNT_BITS > rabt_pkg::OUT_BITS) ?
                                   COUNT_BITS : rabt_pkg::OUT_BITS;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_START  = 10'b00_0000_0010,
        S_MUL_P  = 10'b00_0000_0100,
        S_MUL_NB = 10'b00_0000_1000,
        S_MUL_DD = 10'b00_0001_0000,
        S_MUL_N1 = 10'b00_0010_0000,
        S_MUL_K  = 10'b00_0100_0000,
        S_MUL_PS = 10'b00_1000_0000,
        S_MUL_R  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rabt_pkg::THRESH_BITS-1:0] thresh_reg;

    logic [COUNT_BITS-1:0] above_reg,  above_next;
    logic [COUNT_BITS-1:0] below_reg,  below_next;
    logic [COUNT_BITS-1:0] change_reg, change_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  prev_above_reg, prev_above_next;

    logic [PW-1:0] p_reg,      p_next;
    logic [SW-1:0] spread_reg, spread_next;
    logic [LW-1:0] lhs_reg,    lhs_next;

    logic                        out_valid_reg, out_valid_next;
    logic [rabt_pkg::OUT_BITS-1:0] run_out_reg, above_out_reg, below_out_reg;
    logic                        acc_out_reg, degen_out_reg;
    logic                        out_load;

    logic                  accept;
    logic                  is_above;
    logic [COUNT_BITS-1:0] b_sat;
    logic [NW-1:0]         n_sum;
    logic [NW-1:0]         n_minus1;
    logic [DW-1:0]         pos, neg, delta;
    logic                  degen;
    logic                  verdict;
    logic [OXW-1:0]        run_wide, above_wide, below_wide;

    logic            mul_load;
    logic [LW-1:0]   mul_mcand;
    logic [MW-1:0]   mul_mplier;
    logic [CNTW-1:0] mul_nbits;
    logic [LW-1:0]   product;
    logic            mul_done;

    rabt_mul #(
        .ACC_BITS  (LW),
        .MPY_BITS  (MW),
        .STEP_BITS (CNTW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (mul_load),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .nbits   (mul_nbits),
        .product (product),
        .done    (mul_done)
    );

    // Classify the incoming item
    assign accept   = samples.valid && samples.ready;
    assign is_above = (CMPW'(samples.sample) >= CMPW'(thresh_reg));
    assign samples.ready = (state_reg == S_IDLE);

    // Derived set statistics
    assign b_sat    = (change_reg == '1) ? change_reg : change_reg + COUNT_BITS'(1);
    assign n_sum    = NW'(above_reg) + NW'(below_reg);
    assign n_minus1 = n_sum - NW'(1);
    assign pos      = DW'({product[2*COUNT_BITS:0], 1'b0});
    assign neg      = DW'({p_reg, 2'b00}) + DW'(n_sum);
    assign delta    = (pos >= neg) ? pos - neg : neg - pos;
    assign degen    = (above_reg == '0) || (below_reg == '0);
    assign verdict  = !degen && (lhs_reg <= product);

    // Update the counters on each accepted item; clear them when a result is loaded
    always_comb
    begin
        above_next      = above_reg;
        below_next      = below_reg;
        change_next     = change_reg;
        have_prev_next  = have_prev_reg;
        prev_above_next = prev_above_reg;
        if (accept)
        begin
            if (is_above)
            begin
                if (above_reg != '1)
                begin
                    above_next = above_reg + COUNT_BITS'(1);
                end
            end
            else
            begin
                if (below_reg != '1)
                begin
                    below_next = below_reg + COUNT_BITS'(1);
                end
            end
            if (have_prev_reg && (prev_above_reg != is_above) && (change_reg != '1))
            begin
                change_next = change_reg + COUNT_BITS'(1);
            end
            have_prev_next  = 1'b1;
            prev_above_next = is_above;
        end
        else if (out_load)
        begin
            above_next      = '0;
            below_next      = '0;
            change_next     = '0;
            have_prev_next  = 1'b0;
            prev_above_next = 1'b0;
        end
    end

    // Sequence the products of the test
    always_comb
    begin
        state_next  = state_reg;
        mul_load    = 1'b0;
        mul_mcand   = '0;
        mul_mplier  = '0;
        mul_nbits   = '0;
        p_next      = p_reg;
        spread_next = spread_reg;
        lhs_next    = lhs_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && samples.last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                mul_load   = 1'b1;
                mul_mcand  = LW'(above_reg);
                mul_mplier = MW'(below_reg);
                mul_nbits  = CNTW'(COUNT_BITS);
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                if (mul_done)
                begin
                    p_next     = product[PW-1:0];
                    mul_load   = 1'b1;
                    mul_mcand  = LW'(n_sum);
                    mul_mplier = MW'(b_sat);
                    mul_nbits  = CNTW'(COUNT_BITS);
                    state_next = S_MUL_NB;
                end
            end
            S_MUL_NB:
            begin
                if (mul_done)
                begin
                    spread_next = SW'({p_reg, 1'b0}) - SW'(n_sum);
                    mul_load    = 1'b1;
                    mul_mcand   = LW'(delta);
                    mul_mplier  = MW'(delta);
                    mul_nbits   = CNTW'(DW);
                    state_next  = S_MUL_DD;
                end
            end
            S_MUL_DD:
            begin
                if (mul_done)
                begin
                    mul_load   = 1'b1;
                    mul_mcand  = product;
                    mul_mplier = MW'(n_minus1);
                    mul_nbits  = CNTW'(NW);
                    state_next = S_MUL_N1;
                end
            end
            S_MUL_N1:
            begin
                if (mul_done)
                begin
                    mul_load   = 1'b1;
                    mul_mcand  = product;
                    mul_mplier = MW'(rabt_pkg::K_LHS);
                    mul_nbits  = CNTW'(rabt_pkg::K_LHS_BITS);
                    state_next = S_MUL_K;
                end
            end
            S_MUL_K:
            begin
                if (mul_done)
                begin
                    lhs_next   = product;
                    mul_load   = 1'b1;
                    mul_mcand  = LW'(p_reg);
                    mul_mplier = MW'(spread_reg);
                    mul_nbits  = CNTW'(SW);
                    state_next = S_MUL_PS;
                end
            end
            S_MUL_PS:
            begin
                if (mul_done)
                begin
                    mul_load   = 1'b1;
                    mul_mcand  = product;
                    mul_mplier = MW'(rabt_pkg::K_RHS);
                    mul_nbits  = CNTW'(rabt_pkg::K_RHS_BITS);
                    state_next = S_MUL_R;
                end
            end
            S_MUL_R:
            begin
                if (mul_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand over once the output register is free
                if (!out_valid_reg || verdicts.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drop the result once taken, raise it on a new load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdicts.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign run_wide   = OXW'(b_sat);
    assign above_wide = OXW'(above_reg);
    assign below_wide = OXW'(below_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thresh_reg     <= rabt_pkg::THRESH_RESET;
            above_reg      <= '0;
            below_reg      <= '0;
            change_reg     <= '0;
            have_prev_reg  <= 1'b0;
            prev_above_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            above_reg      <= above_next;
            below_reg      <= below_next;
            change_reg     <= change_next;
            have_prev_reg  <= have_prev_next;
            prev_above_reg <= prev_above_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        spread_reg <= spread_next;
        lhs_reg    <= lhs_next;
        if (out_load)
        begin
            run_out_reg   <= run_wide[rabt_pkg::OUT_BITS-1:0];
            above_out_reg <= above_wide[rabt_pkg::OUT_BITS-1:0];
            below_out_reg <= below_wide[rabt_pkg::OUT_BITS-1:0];
            acc_out_reg   <= verdict;
            degen_out_reg <= degen;
        end
    end

    assign verdicts.valid       = out_valid_reg;
    assign verdicts.run_count   = run_out_reg;
    assign verdicts.above_count = above_out_reg;
    assign verdicts.below_count = below_out_reg;
    assign verdicts.accepted    = acc_out_reg;
    assign verdicts.degenerate  = degen_out_reg;

endmodule

### bench/tb_runs_above_below_test.sv
module tb_runs_above_below_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLE_BITS = 10;
    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned THR_BITS    = rabt_pkg::THRESH_BITS;
    localparam int unsigned OUT_BITS    = rabt_pkg::OUT_BITS;
    localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;

    // 1.96^2 = 38416 / 10000, both sides scaled to integers
    localparam int unsigned Z_SQ_NUM = 38416;
    localparam int unsigned Z_SQ_DEN = 10000;

    // Wait from a set's last item to its verdict, plus a margin
    localparam int unsigned VERDICT_LATENCY = 7 * COUNT_BITS + 47;
    localparam int unsigned SETTLE_CYCLES   = VERDICT_LATENCY + 16;
    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned PHASE_ITEMS     = 190;

    typedef enum int unsigned {
        SET_UNIFORM,
        SET_COIN,
        SET_ALTERNATE,
        SET_CLUMPED,
        SET_ONE_SIDED
    } set_shape_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] runs;
        logic [OUT_BITS-1:0] above;
        logic [OUT_BITS-1:0] below;
        logic                accepted;
        logic                degenerate;
    } verdict_t;

    // Tracks the set in progress and the verdicts still owed by the block
    class verdict_tally_t;
        logic [THR_BITS-1:0] threshold;
        bit                  have_prev;
        bit                  prev_above;
        int unsigned         above_n;
        int unsigned         below_n;
        int unsigned         changes;
        verdict_t            pending[$];
        int unsigned         mismatches;
        int unsigned         verdicts_seen;
        int unsigned         accepted_seen;
        int unsigned         degenerate_seen;

        function new();
            threshold = rabt_pkg::THRESH_RESET;
            mismatches = 0;
            verdicts_seen = 0;
            accepted_seen = 0;
            degenerate_seen = 0;
            clear_set();
        endfunction

        function void clear_set();
            have_prev = 0;
            prev_above = 0;
            above_n = 0;
            below_n = 0;
            changes = 0;
        endfunction

        function int unsigned bump(int unsigned v);
            return (v < COUNT_MAX) ? v + 1 : COUNT_MAX;
        endfunction

        // Two-sided 95% runs test, squared and cleared of fractions
        function bit within_bound(int unsigned n1, int unsigned n2, int unsigned runs);
            bit [127:0] a, b, r, n, p, lead, lag, dev, spread, lhs, rhs;
            a = 128'(n1);
            b = 128'(n2);
            r = 128'(runs);
            n = a + b;
            p = a * b;
            lead = 2 * n * r;
            lag = 4 * p + n;
            dev = (lead >= lag) ? lead - lag : lag - lead;
            spread = 2 * p - n;
            lhs = dev * dev * (n - 1) * Z_SQ_DEN;
            rhs = Z_SQ_NUM * 8 * p * spread;
            return lhs <= rhs;
        endfunction

        function void record_sample(logic [SAMPLE_BITS-1:0] s, logic l);
            bit          up;
            verdict_t    v;
            int unsigned runs;
            up = (s >= threshold);
            if (up)
                above_n = bump(above_n);
            else
                below_n = bump(below_n);
            if (have_prev && prev_above != up)
                changes = bump(changes);
            have_prev = 1;
            prev_above = up;
            if (l)
            begin
                runs = bump(changes);
                v.runs = runs[OUT_BITS-1:0];
                v.above = above_n[OUT_BITS-1:0];
                v.below = below_n[OUT_BITS-1:0];
                v.degenerate = (above_n == 0 || below_n == 0);
                v.accepted = !v.degenerate && within_bound(above_n, below_n, runs);
                pending.push_back(v);
                clear_set();
            end
        endfunction

        function void compare_verdict(verdict_t got);
            verdict_t want;
            verdicts_seen++;
            if (got.accepted === 1'b1)
                accepted_seen++;
            if (got.degenerate === 1'b1)
                degenerate_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected verdict runs=%0d above=%0d below=%0d %s%0b%s%0b",
                             $realtime, got.runs, got.above, got.below, "acc=",
                             got.accepted, " deg=", got.degenerate);
                return;
            end
            want = pending.pop_front();
            if (got.runs !== want.runs || got.above !== want.above ||
                got.below !== want.below || got.accepted !== want.accepted ||
                got.degenerate !== want.degenerate)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: verdict mismatch: expected runs=%0d above=%0d below=%0d %s",
                             $realtime, want.runs, want.above, want.below,
                             $sformatf("acc=%0b deg=%0b", want.accepted, want.degenerate));
                    $display("    got runs=%0d above=%0d below=%0d acc=%0b deg=%0b",
                             got.runs, got.above, got.below, got.accepted, got.degenerate);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [THR_BITS-1:0] cfg_wr_data;

    rabt_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    rabt_out_if verdict_ch ();

    runs_above_below_test #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .samples    (sample_ch.sink),
        .verdicts   (verdict_ch.source)
    );

    verdict_tally_t tally;
    bit             idle_on;
    int unsigned    stall_left = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    items_taken = 0;
    int unsigned    random_sent;
    int unsigned    settings_used;

    // Short directed sets, each entry is {last, sample}
    logic [SAMPLE_BITS:0] directed_items [24] = '{
        {1'b1, 10'd512},
        {1'b0, 10'd0}, {1'b0, 10'd1023}, {1'b0, 10'd511}, {1'b1, 10'd512},
        {1'b0, 10'd0}, {1'b0, 10'd0}, {1'b1, 10'd511},
        {1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b0, 10'd1023},
        {1'b0, 10'd0}, {1'b0, 10'd0}, {1'b0, 10'd0}, {1'b1, 10'd0},
        {1'b0, 10'd0}, {1'b0, 10'd1023}, {1'b0, 10'd1023}, {1'b0, 10'd0},
        {1'b0, 10'd512}, {1'b0, 10'd511}, {1'b0, 10'd511}, {1'b1, 10'd1023}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Verdict side: hold ready low in random bursts, or high throughout once idle_on is clear
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            verdict_ch.ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            verdict_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            verdict_ch.ready <= 1'b0;
        end
        else
        begin
            verdict_ch.ready <= 1'b1;
        end
    end

    // Observe both handshakes and watch for a stuck block
    always @(posedge clk)
    begin
        verdict_t got;
        bit       moved;
        moved = 0;
        if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
        begin
            tally.record_sample(sample_ch.sample, sample_ch.last);
            items_taken++;
            moved = 1;
        end
        if (verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1)
        begin
            got.runs = verdict_ch.run_count;
            got.above = verdict_ch.above_count;
            got.below = verdict_ch.below_count;
            got.accepted = verdict_ch.accepted;
            got.degenerate = verdict_ch.degenerate;
            tally.compare_verdict(got);
            moved = 1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input logic l);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= s;
        sample_ch.last <= l;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
    endtask

    // Drop valid and wait for every owed verdict
    task automatic hold_until_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (tally.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_BITS-1:0] v);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tally.threshold = v;
        settings_used++;
    endtask

    // Pick a sample on the requested side, often right at the boundary
    function automatic logic [SAMPLE_BITS-1:0] side_sample(input bit up);
        int unsigned thr;
        bit          at_edge;
        thr = tally.threshold;
        at_edge = ($urandom_range(0, 3) == 0);
        if (!up && thr != 0)
            return SAMPLE_BITS'(at_edge ? thr - 1 : $urandom_range(thr - 1, 0));
        return SAMPLE_BITS'(at_edge ? thr : $urandom_range(SAMPLE_MAX, thr));
    endfunction

    task automatic send_random_set();
        int unsigned len;
        set_shape_t  shape;
        bit          up;
        logic [SAMPLE_BITS-1:0] s;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        shape = set_shape_t'($urandom_range(SET_UNIFORM, SET_ONE_SIDED));
        up = ($urandom_range(0, 1) != 0);
        for (int unsigned k = 0; k < len; k++)
        begin
            case (shape)
                SET_UNIFORM:   s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
                SET_COIN:      s = side_sample($urandom_range(0, 1) != 0);
                SET_ALTERNATE:
                begin
                    up = ~up;
                    s = side_sample(up);
                end
                SET_CLUMPED:
                begin
                    if ($urandom_range(0, 7) == 0)
                        up = ~up;
                    s = side_sample(up);
                end
                default:       s = side_sample(up);
            endcase
            send_item(s, k == len - 1);
            random_sent++;
        end
    endtask

    initial
    begin
        logic [THR_BITS-1:0] thr_plan [8];
        int unsigned         target;
        tally = new();
        idle_on = 1;
        random_sent = 0;
        settings_used = 1;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sample_ch.last = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets at the reset threshold
        foreach (directed_items[i])
            send_item(directed_items[i][SAMPLE_BITS-1:0], directed_items[i][SAMPLE_BITS]);

        // Random sets over a sweep of thresholds, extremes first
        thr_plan = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd0, 10'd0, 10'd0, 10'd512};
        for (int p = 4; p < 7; p++)
            thr_plan[p] = THR_BITS'($urandom_range(0, SAMPLE_MAX));
        foreach (thr_plan[p])
        begin
            if (p == 7)
                idle_on = 0;
            write_threshold(thr_plan[p]);
            target = random_sent + PHASE_ITEMS;
            while (random_sent < target)
            begin
                if (idle_on && $urandom_range(0, 9) == 0)
                    hold_until_drained();
                send_random_set();
            end
        end

        // Drain and let any stray verdict show up
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tally.pending.size() != 0)
            $display("%0d verdicts never arrived", tally.pending.size());

        $display("Run covered %0d items and %0d verdicts across %0d threshold settings.",
                 items_taken, tally.verdicts_seen, settings_used);
        $display("Verdicts: %0d independence accepted, %0d degenerate, %0d mismatched.",
                 tally.accepted_seen, tally.degenerate_seen, tally.mismatches);
        if (tally.mismatches == 0 && tally.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/rabt_pkg.sv
design/rabt_ifs.sv
design/rabt_mul.sv
design/runs_above_below_test.sv
bench/tb_runs_above_below_test.sv
